// ===== rtl/core/delimited_text_structure_scanner_assert.svh =====
// assertion macros for the delimited text structure scanner
`ifndef DELIMITED_TEXT_STRUCTURE_SCANNER_ASSERT_SVH
`define DELIMITED_TEXT_STRUCTURE_SCANNER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DTSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds
`define DTSS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/dtss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dtss_pkg;

  typedef enum logic [2:0] {
    EV_BLANK   = 3'd0,
    EV_DELIM   = 3'd1,
    EV_EOL     = 3'd2,
    EV_BINARY  = 3'd3,
    EV_DATA    = 3'd4,
    EV_QCOMMA  = 3'd5,
    EV_TERM    = 3'd6
  } event_kind_e;

  // events caused by one byte, at most three
  localparam int MAX_EVENTS = 3;
  typedef logic [1:0] evt_cnt_t;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

endpackage

`default_nettype wire

// ===== rtl/core/dtss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtss_front #(
  parameter int ROW_BYTES  = 65536,
  parameter int TERM_CHARS = 8,
  localparam int CW  = $clog2(ROW_BYTES),
  localparam int SW  = CW + 1,
  localparam int LW  = $clog2(TERM_CHARS + 1),
  localparam int EVW = 3 + CW + SW + 7 + TERM_CHARS + LW,
  localparam int BW  = $bits(dtss_pkg::evt_cnt_t) + dtss_pkg::MAX_EVENTS * EVW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [SW-1:0] cfg_wdata_i,
  input  wire logic          accept_i,
  input  wire logic [7:0]    byte_value_i,
  input  wire logic          row_first_i,
  input  wire logic          row_last_i,
  output logic               push_o,
  output logic [BW-1:0]      bundle_o
);

  localparam int PW = CW + 2;
  localparam logic [PW-1:0] NOPOS   = {PW{1'b1}};
  localparam logic [CW-1:0] COL_MAX = CW'(ROW_BYTES - 1);

  typedef struct packed {
    dtss_pkg::event_kind_e kind;
    logic [CW-1:0]         column;
    logic [SW-1:0]         span;
    logic [6:0]            char_code;
    logic [TERM_CHARS-1:0] term_pat;
    logic [LW-1:0]         term_len;
  } evt_t;

  typedef struct packed {
    dtss_pkg::evt_cnt_t                    count;
    evt_t [dtss_pkg::MAX_EVENTS-1:0]       ev;
  } bundle_t;

  function automatic logic [SW-1:0] span_from(input logic [CW-1:0] c,
                                              input logic [PW-1:0] start);
    logic [PW-1:0] cp;
    cp = PW'(c);
    if (start == NOPOS) begin
      span_from = SW'(cp + PW'(1));
    end else if (start > cp) begin
      span_from = '0;
    end else begin
      span_from = SW'(cp - start);
    end
  endfunction

  logic [SW-1:0]         rw_q;
  logic [CW-1:0]         col_q, col_d, c;
  logic [PW-1:0]         line_q, line_d, cur_line;
  logic [PW-1:0]         comma_q, comma_d, cur_comma;
  logic [PW-1:0]         tab_q, tab_d, cur_tab;
  logic [PW-1:0]         any_q, any_d, cur_any;
  logic [PW-1:0]         aq_q, aq_d, cur_aq;
  logic                  qof_q, qof_d, cur_qof;
  logic                  run_q, run_d, cur_run;
  logic                  stop_q, stop_d, cur_stop;
  logic [TERM_CHARS-1:0] pat_q, pat_d, cur_pat;
  logic [LW-1:0]         len_q, len_d, cur_len;

  logic [PW-1:0] cp, c1;
  logic          prim_v, fw_v, term_v, binary;
  evt_t          prim, fw, term;
  bundle_t       bundle;

  always_comb begin
    // row_first clears the scan state before the byte is handled
    c         = row_first_i ? '0 : col_q;
    cur_line  = row_first_i ? '0 : line_q;
    cur_comma = row_first_i ? NOPOS : comma_q;
    cur_tab   = row_first_i ? NOPOS : tab_q;
    cur_any   = row_first_i ? NOPOS : any_q;
    cur_aq    = row_first_i ? NOPOS : aq_q;
    cur_qof   = row_first_i ? 1'b0 : qof_q;
    cur_run   = row_first_i ? 1'b0 : run_q;
    cur_stop  = row_first_i ? 1'b0 : stop_q;
    cur_pat   = row_first_i ? '0 : pat_q;
    cur_len   = row_first_i ? '0 : len_q;

    col_d   = c;
    line_d  = cur_line;
    comma_d = cur_comma;
    tab_d   = cur_tab;
    any_d   = cur_any;
    aq_d    = cur_aq;
    qof_d   = cur_qof;
    run_d   = cur_run;
    stop_d  = cur_stop;
    pat_d   = cur_pat;
    len_d   = cur_len;

    cp = PW'(c);
    c1 = cp + PW'(1);

    prim_v = 1'b0;
    fw_v   = 1'b0;
    term_v = 1'b0;
    binary = 1'b0;
    prim   = '0;
    fw     = '0;
    term   = '0;
    prim.column = c;
    fw.column   = c;
    term.column = c;
    fw.kind     = dtss_pkg::EV_EOL;
    term.kind   = dtss_pkg::EV_TERM;

    if (!cur_stop) begin
      priority if (byte_value_i == dtss_pkg::CH_SPACE) begin
        prim_v    = 1'b1;
        prim.kind = dtss_pkg::EV_BLANK;
      end else if (byte_value_i == dtss_pkg::CH_QUOTE) begin
        qof_d = cur_qof || (c == '0) || (cur_any != NOPOS && cur_any == cp);
        aq_d  = c1;
      end else if (byte_value_i == dtss_pkg::CH_COMMA) begin
        prim_v         = 1'b1;
        prim.char_code = dtss_pkg::CH_COMMA[6:0];
        if (cur_qof && cur_aq != cp) begin
          prim.kind = dtss_pkg::EV_QCOMMA;
        end else begin
          prim.kind = dtss_pkg::EV_DELIM;
          prim.span = span_from(c, cur_comma);
          comma_d   = c1;
          any_d     = c1;
          qof_d     = 1'b0;
        end
      end else if (byte_value_i == dtss_pkg::CH_TAB) begin
        prim_v         = 1'b1;
        prim.kind      = dtss_pkg::EV_DELIM;
        prim.char_code = dtss_pkg::CH_TAB[6:0];
        prim.span      = span_from(c, cur_tab);
        tab_d          = c1;
        any_d          = c1;
      end else if (byte_value_i == dtss_pkg::CH_CR || byte_value_i == dtss_pkg::CH_LF) begin
        if (!cur_run) begin
          run_d     = 1'b1;
          prim_v    = 1'b1;
          prim.kind = dtss_pkg::EV_EOL;
          prim.span = span_from(c, cur_line);
          pat_d     = TERM_CHARS'(byte_value_i == dtss_pkg::CH_LF);
          len_d     = LW'(1);
        end else if (cur_len < LW'(TERM_CHARS)) begin
          // bit i of the run marks an LF, longer runs saturate
          pat_d = cur_pat | (TERM_CHARS'(byte_value_i == dtss_pkg::CH_LF) << cur_len);
          len_d = cur_len + LW'(1);
        end
        line_d  = c1;
        any_d   = c1;
        comma_d = c1;
        tab_d   = c1;
        qof_d   = 1'b0;
      end else begin
        run_d  = 1'b0;
        prim_v = 1'b1;
        if (byte_value_i[7]) begin
          prim.kind = dtss_pkg::EV_BINARY;
          binary    = 1'b1;
          stop_d    = 1'b1;
        end else begin
          prim.kind      = dtss_pkg::EV_DATA;
          prim.char_code = byte_value_i[6:0];
          if (rw_q > SW'(1) && cur_line <= cp && (cp - cur_line) == PW'(rw_q)) begin
            fw_v    = 1'b1;
            fw.span = SW'(cp - cur_line);
            line_d  = cp - PW'(1);
            any_d   = cp - PW'(1);
            comma_d = cp - PW'(1);
            tab_d   = cp - PW'(1);
          end
        end
      end

      if (row_last_i && len_d != '0 && !binary) begin
        term_v        = 1'b1;
        term.term_pat = pat_d;
        term.term_len = len_d;
      end

      if (!binary && c != COL_MAX) begin
        col_d = c + CW'(1);
      end
    end

    // a fixed-width end of line only follows a data event
    bundle.count = dtss_pkg::evt_cnt_t'({1'b0, prim_v} + {1'b0, fw_v} + {1'b0, term_v});
    bundle.ev[0] = prim_v ? prim : term;
    bundle.ev[1] = fw_v ? fw : term;
    bundle.ev[2] = term;
  end

  assign push_o   = accept_i && (bundle.count != '0);
  assign bundle_o = BW'(bundle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q    <= '0;
      col_q   <= '0;
      line_q  <= '0;
      comma_q <= NOPOS;
      tab_q   <= NOPOS;
      any_q   <= NOPOS;
      aq_q    <= NOPOS;
      qof_q   <= 1'b0;
      run_q   <= 1'b0;
      stop_q  <= 1'b0;
      pat_q   <= '0;
      len_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        rw_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        col_q   <= col_d;
        line_q  <= line_d;
        comma_q <= comma_d;
        tab_q   <= tab_d;
        any_q   <= any_d;
        aq_q    <= aq_d;
        qof_q   <= qof_d;
        run_q   <= run_d;
        stop_q  <= stop_d;
        pat_q   <= pat_d;
        len_q   <= len_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dtss_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtss_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dtss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dtss_back #(
  parameter int ROW_BYTES  = 65536,
  parameter int TERM_CHARS = 8,
  localparam int CW  = $clog2(ROW_BYTES),
  localparam int SW  = CW + 1,
  localparam int LW  = $clog2(TERM_CHARS + 1),
  localparam int EVW = 3 + CW + SW + 7 + TERM_CHARS + LW,
  localparam int BW  = $bits(dtss_pkg::evt_cnt_t) + dtss_pkg::MAX_EVENTS * EVW
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire logic [BW-1:0]  q_data_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output logic [2:0]          event_kind_o,
  output logic [CW-1:0]       column_o,
  output logic [SW-1:0]       span_o,
  output logic [6:0]          char_code_o,
  output logic [TERM_CHARS-1:0] terminator_pattern_o,
  output logic [LW-1:0]       terminator_length_o,
  output logic                last_event_o
);

  typedef struct packed {
    dtss_pkg::event_kind_e kind;
    logic [CW-1:0]         column;
    logic [SW-1:0]         span;
    logic [6:0]            char_code;
    logic [TERM_CHARS-1:0] term_pat;
    logic [LW-1:0]         term_len;
  } evt_t;

  typedef struct packed {
    dtss_pkg::evt_cnt_t              count;
    evt_t [dtss_pkg::MAX_EVENTS-1:0] ev;
  } bundle_t;

  bundle_t            head;
  evt_t               out_q;
  logic               last_q, valid_q, valid_d;
  dtss_pkg::evt_cnt_t idx_q, idx_d;
  logic               load, take, last_slot;

  assign head      = bundle_t'(q_data_i);
  assign last_slot = (idx_q == head.count - dtss_pkg::evt_cnt_t'(1));
  // output register refills in the cycle its beat leaves
  assign load      = !valid_q || pop_i;
  assign take      = load && !q_empty_i;
  assign q_pop_o   = take && last_slot;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (take) begin
      valid_d = 1'b1;
      idx_d   = last_slot ? '0 : idx_q + dtss_pkg::evt_cnt_t'(1);
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q  <= head.ev[idx_q];
      last_q <= last_slot;
    end
  end

  assign empty_o              = !valid_q;
  assign event_kind_o         = 3'(out_q.kind);
  assign column_o             = out_q.column;
  assign span_o               = out_q.span;
  assign char_code_o          = out_q.char_code;
  assign terminator_pattern_o = out_q.term_pat;
  assign terminator_length_o  = out_q.term_len;
  assign last_event_o         = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/delimited_text_structure_scanner.sv =====
// path: a byte's events are stored as one bundle in the event-bundle queue, then leave through the output register
// throughput: one byte per cycle while full is low; results leave one per cycle from the output register
//   while pop is held, and the events of one byte (up to three) leave in order before those of the next byte
// full rises when the four-entry event-bundle queue between scanner and serialiser fills
// reset: asynchronous, clears scan state, record width, queue and the output valid flag at once
`timescale 1ns / 1ps
`default_nettype none
`include "delimited_text_structure_scanner_assert.svh"

module delimited_text_structure_scanner #(
  parameter int ROW_BYTES  = 65536,
  parameter int TERM_CHARS = 8,
  localparam int CW = $clog2(ROW_BYTES),
  localparam int SW = CW + 1,
  localparam int LW = $clog2(TERM_CHARS + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [SW-1:0] cfg_wdata_i,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    byte_value_i,
  input  wire logic          row_first_i,
  input  wire logic          row_last_i,
  output logic               empty,
  input  wire logic          pop,
  output logic [2:0]         event_kind_o,
  output logic [CW-1:0]      column_o,
  output logic [SW-1:0]      span_o,
  output logic [6:0]         char_code_o,
  output logic [TERM_CHARS-1:0] terminator_pattern_o,
  output logic [LW-1:0]      terminator_length_o,
  output logic               last_event_o
);

  localparam int EVW = 3 + CW + SW + 7 + TERM_CHARS + LW;
  localparam int CNW = $bits(dtss_pkg::evt_cnt_t);
  localparam int BW  = CNW + dtss_pkg::MAX_EVENTS * EVW;

  logic          accept;
  logic          q_push, q_full, q_pop, q_empty;
  logic [BW-1:0] q_wdata, q_rdata;

  assign accept = push && !q_full;
  assign full   = q_full;

  dtss_front #(
    .ROW_BYTES  (ROW_BYTES),
    .TERM_CHARS (TERM_CHARS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .byte_value_i (byte_value_i),
    .row_first_i  (row_first_i),
    .row_last_i   (row_last_i),
    .push_o       (q_push),
    .bundle_o     (q_wdata)
  );

  dtss_queue #(
    .WIDTH (BW),
    .DEPTH (dtss_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  dtss_back #(
    .ROW_BYTES  (ROW_BYTES),
    .TERM_CHARS (TERM_CHARS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_empty_i            (q_empty),
    .q_data_i             (q_rdata),
    .q_pop_o              (q_pop),
    .empty_o              (empty),
    .pop_i                (pop),
    .event_kind_o         (event_kind_o),
    .column_o             (column_o),
    .span_o               (span_o),
    .char_code_o          (char_code_o),
    .terminator_pattern_o (terminator_pattern_o),
    .terminator_length_o  (terminator_length_o),
    .last_event_o         (last_event_o)
  );

  `DTSS_ASSERT_NEVER(a_pop_when_empty, q_pop && q_empty, "bundle taken from empty queue")
  `DTSS_ASSERT_IMP(a_push_has_events, q_push, q_wdata[BW-1 -: CNW] != '0, "empty bundle queued")
  `DTSS_ASSERT_IMP(a_blank_on_new_row, accept && row_first_i && byte_value_i == dtss_pkg::CH_SPACE, q_push, "blank at row start lost")

endmodule

`default_nettype wire
